// File: design/rchd_pkg.sv
// ----------------------------------------------------------------------------
// rchd_pkg: shared constants for the ray against circle distance unit
// Holds the default word size that the top level hands to its parameter.
// ----------------------------------------------------------------------------
package rchd_pkg;

  // Width of one raw fixed-point word on the ports.
  localparam int unsigned WORD_BITS_DEF = 32;

endpackage

// File: design/ray_circle_hit_distance.sv
// ----------------------------------------------------------------------------
// ray_circle_hit_distance: distance along a ray to its first circle crossing
// Fully pipelined: products, a restoring square root stage per result bit and
// a restoring divider stage per quotient bit, one ray per clock unless the output stalls.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in      | receive   | in_valid_i, in_stall_o | dir_x/y, center_x/y, radius
//   out     | send      | out_valid_o,out_stall_i| hit, distance
//
// One transfer per clock is sustained while the output is not stalled.
// The pipeline has 2*WORD_BITS square root stages and 2*WORD_BITS+1 divider stages.
// Reset clears only the valid bits of the stages.
// A stall at the output freezes the whole pipeline, including the output
// register, so no transfer is lost or repeated.
module ray_circle_hit_distance #(
  parameter int unsigned WORD_BITS = rchd_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] dir_x_i,
  input  logic [WORD_BITS-1:0] dir_y_i,
  input  logic [WORD_BITS-1:0] center_x_i,
  input  logic [WORD_BITS-1:0] center_y_i,
  input  logic [WORD_BITS-2:0] radius_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic [WORD_BITS-1:0] distance_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned RW = 4 * W;
  localparam int unsigned SQ = 2 * W;
  localparam int unsigned N  = PW + 1;
  localparam logic [N-1:0] SAT_NEG = {{(N-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [N-1:0] SAT_POS = SAT_NEG - 1'b1;

  logic adv;
  logic out_valid_q;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;

  // Front stages: valid bits.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  // Stage 1: signed products and the unsigned square of the radius.
  logic signed [PW-1:0] m_axpx, m_aypy, m_axpy, m_aypx, m_axax, m_ayay;
  logic        [PW-1:0] m_rr;
  logic signed [PW-1:0] axpx_q, aypy_q, axpy_q, aypx_q, axax_q, ayay_q;
  logic        [PW-1:0] rr1_q;

  assign m_axpx = $signed(dir_x_i) * $signed(center_x_i);
  assign m_aypy = $signed(dir_y_i) * $signed(center_y_i);
  assign m_axpy = $signed(dir_x_i) * $signed(center_y_i);
  assign m_aypx = $signed(dir_y_i) * $signed(center_x_i);
  assign m_axax = $signed(dir_x_i) * $signed(dir_x_i);
  assign m_ayay = $signed(dir_y_i) * $signed(dir_y_i);
  assign m_rr   = {1'b0, radius_i} * {1'b0, radius_i};

  // Stage 2: dot, cross and squared length.
  logic signed [PW:0]   d2_q, c2_q;
  logic        [PW-1:0] l2_2_q, rr2_q;

  // Stage 3: magnitude of the cross product.
  logic signed [PW:0]   d3_q;
  logic                 dpos3_q;
  logic        [PW-1:0] cabs3_q, l2_3_q, rr3_q;
  logic        [PW:0]   c_neg;

  assign c_neg = -c2_q;

  // Stage 4: half-word partial products of r^2*L2 and C^2.
  logic signed [PW:0]   d4_q;
  logic                 dpos4_q;
  logic        [PW-1:0] l2_4_q;
  logic [PW-1:0] rhh_q, rhl_q, rlh_q, rll_q, chh_q, chl_q, clh_q, cll_q;

  // Stage 5: cross terms summed.
  logic signed [PW:0]   d5_q;
  logic                 dpos5_q;
  logic        [PW-1:0] l2_5_q;
  logic        [PW:0]   rmid_q, cmid_q;
  logic        [RW-1:0] rout_q, cout_q;

  // Stage 6: full products.
  logic signed [PW:0]   d6_q;
  logic                 dpos6_q;
  logic        [PW-1:0] l2_6_q;
  logic        [RW-1:0] r2l2_q, csq_q;

  // Stage 7 input: radicand and miss test.
  logic [RW:0] diff;
  logic        miss7;

  assign diff  = {1'b0, r2l2_q} - {1'b0, csq_q};
  assign miss7 = !dpos6_q || diff[RW] || (diff[RW-1:0] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      axpx_q <= m_axpx;
      aypy_q <= m_aypy;
      axpy_q <= m_axpy;
      aypx_q <= m_aypx;
      axax_q <= m_axax;
      ayay_q <= m_ayay;
      rr1_q  <= m_rr;

      d2_q   <= $signed({axpx_q[PW-1], axpx_q}) + $signed({aypy_q[PW-1], aypy_q});
      c2_q   <= $signed({axpy_q[PW-1], axpy_q}) - $signed({aypx_q[PW-1], aypx_q});
      l2_2_q <= axax_q + ayay_q;
      rr2_q  <= rr1_q;

      d3_q    <= d2_q;
      dpos3_q <= !d2_q[PW] && (d2_q != '0);
      cabs3_q <= c2_q[PW] ? c_neg[PW-1:0] : c2_q[PW-1:0];
      l2_3_q  <= l2_2_q;
      rr3_q   <= rr2_q;

      d4_q    <= d3_q;
      dpos4_q <= dpos3_q;
      l2_4_q  <= l2_3_q;
      rhh_q   <= rr3_q[PW-1:W] * l2_3_q[PW-1:W];
      rhl_q   <= rr3_q[PW-1:W] * l2_3_q[W-1:0];
      rlh_q   <= rr3_q[W-1:0] * l2_3_q[PW-1:W];
      rll_q   <= rr3_q[W-1:0] * l2_3_q[W-1:0];
      chh_q   <= cabs3_q[PW-1:W] * cabs3_q[PW-1:W];
      chl_q   <= cabs3_q[PW-1:W] * cabs3_q[W-1:0];
      clh_q   <= cabs3_q[W-1:0] * cabs3_q[PW-1:W];
      cll_q   <= cabs3_q[W-1:0] * cabs3_q[W-1:0];

      d5_q    <= d4_q;
      dpos5_q <= dpos4_q;
      l2_5_q  <= l2_4_q;
      rmid_q  <= {1'b0, rhl_q} + {1'b0, rlh_q};
      cmid_q  <= {1'b0, chl_q} + {1'b0, clh_q};
      rout_q  <= {rhh_q, rll_q};
      cout_q  <= {chh_q, cll_q};

      d6_q    <= d5_q;
      dpos6_q <= dpos5_q;
      l2_6_q  <= l2_5_q;
      r2l2_q  <= rout_q + {{(W-1){1'b0}}, rmid_q, {W{1'b0}}};
      csq_q   <= cout_q + {{(W-1){1'b0}}, cmid_q, {W{1'b0}}};
    end
  end

  // Square root pipeline: one result bit per stage. The first W stages also
  // take the root of the squared length.
  logic                 sqv_q   [SQ+1];
  logic [RW-1:0]        sq_rad_q  [SQ+1];
  logic [PW+1:0]        sq_rem_q  [SQ+1];
  logic [PW-1:0]        sq_root_q [SQ+1];
  logic [PW-1:0]        lq_rad_q  [SQ+1];
  logic [W+1:0]         lq_rem_q  [SQ+1];
  logic [W-1:0]         lq_root_q [SQ+1];
  logic signed [PW:0]   sq_d_q    [SQ+1];
  logic                 sq_miss_q [SQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (adv) begin
      v7_q <= v6_q;
    end
  end

  assign sqv_q[0] = v7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rad_q[0]  <= diff[RW-1:0];
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      lq_rad_q[0]  <= l2_6_q;
      lq_rem_q[0]  <= '0;
      lq_root_q[0] <= '0;
      sq_d_q[0]    <= d6_q;
      sq_miss_q[0] <= miss7;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [PW+1:0] rem_n, trial;
    logic          ge;

    assign rem_n = {sq_rem_q[k][PW-1:0], sq_rad_q[k][RW-1 -: 2]};
    assign trial = {sq_root_q[k], 2'b01};
    assign ge    = rem_n >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k+1] <= 1'b0;
      end else if (adv) begin
        sqv_q[k+1] <= sqv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rad_q[k+1]  <= sq_rad_q[k] << 2;
        sq_rem_q[k+1]  <= ge ? (rem_n - trial) : rem_n;
        sq_root_q[k+1] <= {sq_root_q[k][PW-2:0], ge};
        sq_d_q[k+1]    <= sq_d_q[k];
        sq_miss_q[k+1] <= sq_miss_q[k];
      end
    end

    if (k < W) begin : g_len
      logic [W+1:0] lrem_n, ltrial;
      logic         lge;

      assign lrem_n = {lq_rem_q[k][W-1:0], lq_rad_q[k][PW-1 -: 2]};
      assign ltrial = {lq_root_q[k], 2'b01};
      assign lge    = lrem_n >= ltrial;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          lq_rad_q[k+1]  <= lq_rad_q[k] << 2;
          lq_rem_q[k+1]  <= lge ? (lrem_n - ltrial) : lrem_n;
          lq_root_q[k+1] <= {lq_root_q[k][W-2:0], lge};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (adv) begin
          lq_rad_q[k+1]  <= lq_rad_q[k];
          lq_rem_q[k+1]  <= lq_rem_q[k];
          lq_root_q[k+1] <= lq_root_q[k];
        end
      end
    end
  end

  // D - S, then its sign and magnitude.
  logic                 t1v_q, t2v_q;
  logic signed [PW+1:0] t1_q;
  logic        [W-1:0]  t1_lq_q;
  logic                 t1_miss_q;
  logic        [PW+1:0] t_neg;

  assign t_neg = -t1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1v_q <= 1'b0;
      t2v_q <= 1'b0;
    end else if (adv) begin
      t1v_q <= sqv_q[SQ];
      t2v_q <= t1v_q;
    end
  end

  // Divider pipeline: one quotient bit per stage.
  logic          dv_q    [N+1];
  logic [N-1:0]  dvd_q   [N+1];
  logic [W-1:0]  drem_q  [N+1];
  logic [N-1:0]  dquo_q  [N+1];
  logic [W-1:0]  dlq_q   [N+1];
  logic          dneg_q  [N+1];
  logic          dmiss_q [N+1];

  assign dv_q[0] = t2v_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q      <= $signed({sq_d_q[SQ][PW], sq_d_q[SQ]}) - $signed({2'b00, sq_root_q[SQ]});
      t1_lq_q   <= lq_root_q[SQ];
      t1_miss_q <= sq_miss_q[SQ];

      dvd_q[0]   <= t1_q[PW+1] ? t_neg[N-1:0] : t1_q[N-1:0];
      dneg_q[0]  <= t1_q[PW+1];
      drem_q[0]  <= '0;
      dquo_q[0]  <= '0;
      dlq_q[0]   <= t1_lq_q;
      dmiss_q[0] <= t1_miss_q || (t1_lq_q == '0);
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_div
    logic [W:0] rem_n, sub;
    logic       ge;

    assign rem_n = {drem_q[j], dvd_q[j][N-1]};
    assign sub   = rem_n - {1'b0, dlq_q[j]};
    assign ge    = rem_n >= {1'b0, dlq_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dvd_q[j+1]   <= dvd_q[j] << 1;
        drem_q[j+1]  <= ge ? sub[W-1:0] : rem_n[W-1:0];
        dquo_q[j+1]  <= {dquo_q[j][N-2:0], ge};
        dlq_q[j+1]   <= dlq_q[j];
        dneg_q[j+1]  <= dneg_q[j];
        dmiss_q[j+1] <= dmiss_q[j];
      end
    end
  end

  // Saturation into the output register.
  logic [N-1:0] q_sat;
  logic [W-1:0] dist_d;

  always_comb begin
    if (dneg_q[N]) begin
      q_sat  = (dquo_q[N] > SAT_NEG) ? SAT_NEG : dquo_q[N];
      dist_d = ~q_sat[W-1:0] + 1'b1;
    end else begin
      q_sat  = (dquo_q[N] > SAT_POS) ? SAT_POS : dquo_q[N];
      dist_d = q_sat[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_o      <= !dmiss_q[N];
      distance_o <= dmiss_q[N] ? '0 : dist_d;
    end
  end

endmodule
